// ----- hdl/signed_decimal_seven_segment_driver_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal seven-segment driver
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_SEVEN_SEGMENT_DRIVER_DEFINES_SVH
`define SIGNED_DECIMAL_SEVEN_SEGMENT_DRIVER_DEFINES_SVH

// Check a same-cycle implication, skipped while reset is asserted
`define SDSD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication, skipped while reset is asserted
`define SDSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sdsd_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsd_pkg
// Shared widths, segment codes and the digit-to-segment table.
// ----------------------------------------------------------------------------
package sdsd_pkg;

    localparam int VALUE_W     = 11;
    localparam int SEG_W       = 8;
    localparam int BCD_W       = 4;
    localparam int S_DATA_W    = 16;

    // Divide by ten as (t * 205) >> 11, exact for t up to 1028
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_MUL_W = 8;
    localparam int DIV10_SHIFT = 11;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h7F;
    localparam logic [SEG_W-1:0] SEG_D0    = 8'h81;
    localparam logic [SEG_W-1:0] SEG_D1    = 8'hF3;
    localparam logic [SEG_W-1:0] SEG_D2    = 8'h49;
    localparam logic [SEG_W-1:0] SEG_D3    = 8'h61;
    localparam logic [SEG_W-1:0] SEG_D4    = 8'h33;
    localparam logic [SEG_W-1:0] SEG_D5    = 8'h25;
    localparam logic [SEG_W-1:0] SEG_D6    = 8'h05;
    localparam logic [SEG_W-1:0] SEG_D7    = 8'hF1;
    localparam logic [SEG_W-1:0] SEG_D8    = 8'h01;
    localparam logic [SEG_W-1:0] SEG_D9    = 8'h21;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [SEG_W-1:0] seg_t;

    // Largest magnitude that fits in the given number of decimal digits
    function automatic logic [31:0] max_magnitude(input int digits);
        logic [31:0] lim;
        lim = 32'd1;
        for (int k = 0; k < digits; k++) begin
            lim = lim * 32'd10;
        end
        return lim - 32'd1;
    endfunction

    // Map one decimal digit to its active-low segment pattern
    function automatic seg_t seg_of_digit(input bcd_t d);
        seg_t seg;
        unique case (d)
            4'd0:    seg = SEG_D0;
            4'd1:    seg = SEG_D1;
            4'd2:    seg = SEG_D2;
            4'd3:    seg = SEG_D3;
            4'd4:    seg = SEG_D4;
            4'd5:    seg = SEG_D5;
            4'd6:    seg = SEG_D6;
            4'd7:    seg = SEG_D7;
            4'd8:    seg = SEG_D8;
            4'd9:    seg = SEG_D9;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- hdl/sdsd_front.sv -----
// ----------------------------------------------------------------------------
// sdsd_front
// Take one signed value, saturate its magnitude and split it into decimal
// digits, one digit per cycle, then push sign and digits once queue has room.
// ----------------------------------------------------------------------------
module sdsd_front
    import sdsd_pkg::*;
#(
    parameter int DIGITS = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [VALUE_W-1:0]         in_value,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic [BCD_W*DIGITS:0]      q_data
);

    localparam int STEP_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int PROD_W = VALUE_W + DIV10_MUL_W;
    localparam int QUOT_W = PROD_W - DIV10_SHIFT;
    localparam logic [31:0] MAX_MAG = max_magnitude(DIGITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGITS - 1);

    logic                      busy_reg,  busy_next;
    logic [STEP_W-1:0]         step_reg,  step_next;
    logic                      neg_reg,   neg_next;
    logic [VALUE_W-1:0]        work_reg,  work_next;
    logic [BCD_W*DIGITS-1:0]   dig_reg,   dig_next;

    logic                      accept;
    logic                      last_step;
    logic                      advance;
    logic [VALUE_W-1:0]        mag;
    logic [VALUE_W-1:0]        mag_sat;
    logic [PROD_W-1:0]         prod;
    logic [QUOT_W-1:0]         quot;
    logic [VALUE_W-1:0]        rem;
    logic [BCD_W*DIGITS-1:0]   dig_shift;

    // Magnitude of the two's-complement input, clamped to the digit range
    assign mag     = in_value[VALUE_W-1] ? VALUE_W'(~in_value + 1'b1) : in_value;
    assign mag_sat = (32'(mag) > MAX_MAG) ? MAX_MAG[VALUE_W-1:0] : mag;

    // One divide-by-ten step: quotient by reciprocal, remainder by subtract
    assign prod = PROD_W'(work_reg) * PROD_W'(DIV10_MUL);
    assign quot = prod[PROD_W-1:DIV10_SHIFT];
    assign rem  = work_reg - (VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0}));

    // New digit enters at the top; units end up in the lowest slot
    generate
        if (DIGITS > 1) begin : g_shift
            assign dig_shift = {rem[BCD_W-1:0], dig_reg[BCD_W*DIGITS-1:BCD_W]};
        end else begin : g_single
            assign dig_shift = rem[BCD_W-1:0];
        end
    endgenerate

    assign last_step = busy_reg && (step_reg == LAST_STEP);
    assign advance   = busy_reg && (!last_step || q_ready);
    assign in_ready  = !busy_reg || (last_step && q_ready);
    assign accept    = in_valid && in_ready;

    assign q_valid = last_step;
    assign q_data  = {neg_reg, dig_shift};

    // Sequence the digit extraction
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        work_next = work_reg;
        dig_next  = dig_reg;
        if (advance) begin
            work_next = VALUE_W'(quot);
            dig_next  = dig_shift;
            step_next = step_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = in_value[VALUE_W-1];
            work_next = mag_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        neg_reg  <= neg_next;
        work_reg <= work_next;
        dig_reg  <= dig_next;
    end

endmodule

// ----- hdl/sdsd_queue.sv -----
// ----------------------------------------------------------------------------
// sdsd_queue
// Two-entry queue between the digit splitter and the segment sequencer.
// ----------------------------------------------------------------------------
module sdsd_queue #(
    parameter int WIDTH = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/sdsd_back.sv -----
// ----------------------------------------------------------------------------
// sdsd_back
// Walk one queued entry position by position: sign, then digits from the
// highest down, blanking leading zeros, into the output register.
// ----------------------------------------------------------------------------
module sdsd_back
    import sdsd_pkg::*;
#(
    parameter int DIGITS = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [BCD_W*DIGITS:0]  q_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SEG_W-1:0]       m_tdata,
    output logic                   m_tlast
);

    localparam int POS_W = $clog2(DIGITS + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS);

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic             leading_reg, leading_next;
    logic             valid_reg,   valid_next;
    seg_t             data_reg,    data_next;
    logic             last_reg,    last_next;

    logic             load;
    logic             is_last;
    bcd_t             digit;
    logic             blank;
    seg_t             seg;

    assign load    = q_valid && (!valid_reg || m_tready);
    assign is_last = (pos_reg == LAST_POS);
    assign q_ready = load && is_last;

    // Select the digit for this position; position one is the highest digit
    always_comb begin
        digit = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (pos_reg == POS_W'(DIGITS - k)) begin
                digit = q_data[BCD_W*k +: BCD_W];
            end
        end
    end

    // Form the segment byte for the current position
    assign blank = leading_reg && (digit == '0) && !is_last;
    always_comb begin
        if (pos_reg == '0) begin
            seg = q_data[BCD_W*DIGITS] ? SEG_MINUS : SEG_BLANK;
        end else if (blank) begin
            seg = SEG_BLANK;
        end else begin
            seg = seg_of_digit(digit);
        end
    end

    // Load the output register and step through positions
    always_comb begin
        pos_next     = pos_reg;
        leading_next = leading_reg;
        valid_next   = valid_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            data_next  = seg;
            last_next  = is_last;
            if (is_last) begin
                pos_next     = '0;
                leading_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg != '0 && !blank) begin
                    leading_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            leading_reg <= 1'b1;
            valid_reg   <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            leading_reg <= leading_next;
            valid_reg   <= valid_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hdl/signed_decimal_seven_segment_driver.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_driver
// Signed value in, one active-low seven-segment byte per display position out.
// ----------------------------------------------------------------------------
// Each accepted value produces DIGITS + 1 bytes: the sign position (minus or
// blank), then the digits from the highest to the units with leading zeros
// blanked; tlast marks the units byte. Magnitudes saturate to DIGITS nines.
// The output channel sets the pace while m_tready stays high. The digit
// splitter does one multiply-by-reciprocal divide by ten per cycle, its last
// step waiting for room in the queue, and a two-entry queue lets it work on
// the next value while bytes go out. A value passes through the splitter
// steps, the queue and the output register on its way to its first byte.
// ----------------------------------------------------------------------------
module signed_decimal_seven_segment_driver
    import sdsd_pkg::*;
#(
    parameter int DIGITS = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [10:0] value, [15:11] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SEG_W-1:0]    m_tdata,   // [7:0] segment_byte
    output logic                m_tlast
);

    localparam int ENTRY_W = BCD_W * DIGITS + 1;

    logic               fq_valid;
    logic               fq_ready;
    logic [ENTRY_W-1:0] fq_data;
    logic               qb_valid;
    logic               qb_ready;
    logic [ENTRY_W-1:0] qb_data;

    sdsd_front #(
        .DIGITS   (DIGITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_value (s_tdata[VALUE_W-1:0]),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    sdsd_queue #(
        .WIDTH    (ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    sdsd_back #(
        .DIGITS   (DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/sdsd_checker.sv -----
// ----------------------------------------------------------------------------
// sdsd_checker
// Port-level checks on the output byte stream of the display driver.
// ----------------------------------------------------------------------------
`include "signed_decimal_seven_segment_driver_defines.svh"

module sdsd_checker
    import sdsd_pkg::*;
#(
    parameter int DIGITS = 3
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SEG_W-1:0]    m_tdata,
    input logic                m_tlast
);

    localparam int CNT_W = $clog2(DIGITS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             m_fire;

    assign m_fire = m_tvalid && m_tready;

    // Count bytes within the current group
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (m_fire) begin
            cnt_reg <= m_tlast ? '0 : cnt_reg + 1'b1;
        end
    end

    `SDSD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output byte changed while stalled")
    `SDSD_ASSERT_NOW(a_group_len, aclk, aresetn, m_fire, m_tlast == (cnt_reg == CNT_W'(DIGITS)), "latch mark not on the last byte of a group")
    `SDSD_ASSERT_NOW(a_units_shown, aclk, aresetn, m_tvalid && m_tlast, m_tdata != SEG_BLANK && m_tdata != SEG_MINUS, "units position not showing a digit")
    `SDSD_ASSERT_NOW(a_minus_first, aclk, aresetn, m_tvalid && cnt_reg != '0, m_tdata != SEG_MINUS, "minus pattern outside the sign position")

endmodule

bind signed_decimal_seven_segment_driver sdsd_checker #(.DIGITS(DIGITS)) u_checker (.*);

// ----- bench/signed_decimal_seven_segment_driver_tb.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_driver_tb
// Self-checking bench for the signed decimal seven-segment driver.
// ----------------------------------------------------------------------------
// Sends signed values over the input stream and predicts the four segment
// bytes that each one yields: sign position, hundreds, tens and units, with
// leading zeros blanked and tlast on the units byte. Directed values cover
// zero, the range ends, saturation and every digit. Random values follow
// under four flow-control phases: free running, sender idling, receiver
// stalling, and both at once. A watchdog ends the run if the streams hang.
// ----------------------------------------------------------------------------
module signed_decimal_seven_segment_driver_tb;
    import sdsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIGITS    = 3;
    localparam int MAX_MAG       = 10 ** NUM_DIGITS - 1;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    localparam seg_t DIGIT_SEGS [10] = '{
        SEG_D0, SEG_D1, SEG_D2, SEG_D3, SEG_D4,
        SEG_D5, SEG_D6, SEG_D7, SEG_D8, SEG_D9
    };

    localparam int DIRECTED [20] = '{
        0, 1, -1, 9, 10, 99, 100, 999, -999, 1000,
        -1000, 1023, -1024, 105, -5, 50, -60, 123, 456, -789
    };

    typedef struct packed {
        seg_t seg;
        logic last;
    } segment_byte_t;

    // ------------------------------------------------------------------------
    // Expected-byte store with its own display predictor
    // ------------------------------------------------------------------------
    class display_scoreboard;
        segment_byte_t expected_bytes[$];
        int values_seen;
        int clamped_seen;
        int bytes_checked;
        int mismatches;

        function new();
            values_seen   = 0;
            clamped_seen  = 0;
            bytes_checked = 0;
            mismatches    = 0;
        endfunction

        // Predict the sign byte and the digit bytes for one accepted value
        function void note_value(input logic [VALUE_W-1:0] raw);
            int            mag;
            int            digit [NUM_DIGITS];
            bit            neg;
            bit            leading;
            segment_byte_t b;
            neg = raw[VALUE_W-1];
            mag = neg ? (1 << VALUE_W) - int'(raw) : int'(raw);
            if (mag > MAX_MAG) begin
                mag = MAX_MAG;
                clamped_seen++;
            end
            for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
                digit[k] = mag % 10;
                mag      = mag / 10;
            end
            b.seg  = neg ? SEG_MINUS : SEG_BLANK;
            b.last = 1'b0;
            expected_bytes.push_back(b);
            leading = 1'b1;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                if (leading && digit[k] == 0 && k != NUM_DIGITS - 1) begin
                    b.seg = SEG_BLANK;
                end else begin
                    leading = 1'b0;
                    b.seg   = DIGIT_SEGS[digit[k]];
                end
                b.last = (k == NUM_DIGITS - 1);
                expected_bytes.push_back(b);
            end
            values_seen++;
        endfunction

        // Compare one accepted output byte with the oldest prediction
        function void check_byte(input seg_t seg, input logic last);
            segment_byte_t exp_b;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected byte seg=%02h last=%b", $time, seg, last);
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (seg !== exp_b.seg || last !== exp_b.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: byte mismatch: expected seg=%02h last=%b, got seg=%02h last=%b",
                             $time, exp_b.seg, exp_b.last, seg, last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // [10:0] value, [15:11] zero
    logic                m_tvalid;
    logic                m_tready;
    logic [SEG_W-1:0]    m_tdata;    // [7:0] segment_byte
    logic                m_tlast;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    display_scoreboard sb = new();

    signed_decimal_seven_segment_driver #(
        .DIGITS(NUM_DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stall the output stream at the rate of the current phase
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Record accepted items on both streams, and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_value(s_tdata[VALUE_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("signed_decimal_seven_segment_driver_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one value, idling first at the current sender rate
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_DATA_W - VALUE_W){1'b0}}, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly in-range values, some small ones for blanking, some raw 11-bit codes
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return VALUE_W'($urandom_range(2 * MAX_MAG) - MAX_MAG);
        else if (pick < 8)
            return VALUE_W'($urandom_range(198) - 99);
        else
            return VALUE_W'($urandom);
    endfunction

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed values: zero, range ends, saturation, every digit
        foreach (DIRECTED[i])
            send_value(VALUE_W'(DIRECTED[i]));

        // Random values over the flow-control phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            repeat (ITEMS_PER_PHASE) send_value(random_value());
        end
        s_tvalid = 1'b0;

        // Drain, then keep clocking to catch stray bytes
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * (NUM_DIGITS + 1) + 4) @(posedge aclk);

        $display("Covered %0d values (%0d saturated) and %0d segment bytes",
                 sb.values_seen, sb.clamped_seen, sb.bytes_checked);
        $display("over free-running, sender-idle, receiver-stall and mixed phases; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("signed_decimal_seven_segment_driver_tb: PASS");
        end else begin
            $display("signed_decimal_seven_segment_driver_tb: FAIL");
        end
        $finish;
    end

endmodule
